// ===== rtl/core/dtf_pkg.sv =====
// shared constants for the dual thermistor to fahrenheit converter
`timescale 1ns / 1ps
`default_nettype none
package dtf_pkg;
  localparam int ADC_BITS_DEF = 10;
  localparam int DIV_BITS = 24;
  localparam logic [DIV_BITS-1:0] DIVIDEND = 24'd10240000;
  localparam logic [DIV_BITS-1:0] SERIES_OHMS = 24'd10000;
  localparam int SQ_STEPS = 28;
  localparam int QUO_BITS = 18;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [41:0] COEF_A_Q48 = 42'd317387682190;
  localparam logic [27:0] COEF_B_Q40 = 28'd257673681;
  localparam logic [24:0] COEF_C_Q48 = 25'd24482861;
  localparam logic [55:0] SCALE_Q48 = 56'd180 << 48;
  localparam logic signed [19:0] KELVIN_FAHR_CENTI = 20'sd45967;
  localparam int LANE_LAT = DIV_BITS + 3 + SQ_STEPS + 5 + QUO_BITS;
  localparam int PADDR_BITS = 3;
  localparam logic REG_OFFSET = 1'b0;
endpackage
`default_nettype wire

// ===== rtl/core/dual_thermistor_to_fahrenheit.sv =====
// top level of the dual thermistor to fahrenheit converter
// Converts two thermistor ADC readings per transfer to hundredths of a degree
// Fahrenheit through a Steinhart-Hart fit, plus the floor of their mean. A new
// sample pair is taken every cycle unless the output holds; each result passes
// through the 24-stage resistance divider, the 28 squaring stages of the log
// and the 18-stage reciprocal divider in each lane. The whole pipeline holds
// while a result waits at the output, so in_ready drops only in cycles where
// out_valid is high and out_ready is low. A zero sample sets its fault bit and
// forces its temperature and the mean to zero.
`timescale 1ns / 1ps
`default_nettype none
module dual_thermistor_to_fahrenheit import dtf_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADC_BITS-1:0]   sample_a,
  input  logic [ADC_BITS-1:0]   sample_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [17:0]           temp_a,
  output logic [17:0]           temp_b,
  output logic [17:0]           temp_mean,
  output logic [1:0]            fault
);
  logic                en;
  logic [11:0]         offset;
  logic [LANE_LAT-1:0] vpipe;
  logic [1:0]          fpipe [0:LANE_LAT-1];
  logic [QUO_BITS-1:0] quo_a;
  logic [QUO_BITS-1:0] quo_b;

  assign pready = 1'b1;
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign prdata = (paddr[2] == REG_OFFSET) ? {{20{offset[11]}}, offset} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_OFFSET) begin
      offset <= pwdata[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vpipe     <= {vpipe[LANE_LAT-2:0], in_valid};
      out_valid <= vpipe[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fpipe[0] <= {sample_b == '0, sample_a == '0};
      for (int i = 1; i < LANE_LAT; i++) begin
        fpipe[i] <= fpipe[i-1];
      end
    end
  end

  dtf_lane #(.ADC_BITS(ADC_BITS)) u_lane_a (
    .clk    (clk),
    .en     (en),
    .sample (sample_a),
    .quo    (quo_a)
  );

  dtf_lane #(.ADC_BITS(ADC_BITS)) u_lane_b (
    .clk    (clk),
    .en     (en),
    .sample (sample_b),
    .quo    (quo_b)
  );

  dtf_merge u_merge (
    .clk       (clk),
    .en        (en),
    .quo_a     (quo_a),
    .quo_b     (quo_b),
    .flt       (fpipe[LANE_LAT-1]),
    .offset    (offset),
    .temp_a    (temp_a),
    .temp_b    (temp_b),
    .temp_mean (temp_mean),
    .fault     (fault)
  );

  a_mean_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault != 2'b00 |-> temp_mean == '0)
    else $error("mean not cleared on fault");

  a_temp_a_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault[0] |-> temp_a == '0)
    else $error("temp_a not cleared on fault");

  a_temp_b_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault[1] |-> temp_b == '0)
    else $error("temp_b not cleared on fault");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && vpipe == '0)
    else $error("pipeline not empty after reset");
endmodule
`default_nettype wire

// ===== rtl/core/dtf_lane.sv =====
// one conversion lane: divide, log, polynomial and reciprocal pipeline
`timescale 1ns / 1ps
`default_nettype none
module dtf_lane import dtf_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [ADC_BITS-1:0] sample,
  output logic [QUO_BITS-1:0] quo
);
  // resistance divider, one quotient bit per stage
  logic [ADC_BITS-1:0] dv_rem [1:DIV_BITS];
  logic [ADC_BITS-1:0] dv_den [1:DIV_BITS];
  logic [DIV_BITS-1:0] dv_quo [1:DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    logic [ADC_BITS-1:0] prev_rem;
    logic [ADC_BITS-1:0] prev_den;
    logic [DIV_BITS-1:0] prev_quo;
    logic [ADC_BITS:0]   trial;
    logic [ADC_BITS:0]   diff;
    logic                ge;
    if (k == 0) begin : g_first
      assign prev_rem = '0;
      assign prev_den = sample;
      assign prev_quo = '0;
    end else begin : g_next
      assign prev_rem = dv_rem[k];
      assign prev_den = dv_den[k];
      assign prev_quo = dv_quo[k];
    end
    assign trial = {prev_rem, DIVIDEND[DIV_BITS-1-k]};
    assign diff = trial - {1'b0, prev_den};
    assign ge = trial >= {1'b0, prev_den};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k+1] <= ge ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
        dv_den[k+1] <= prev_den;
        dv_quo[k+1] <= {prev_quo[DIV_BITS-2:0], ge};
      end
    end
  end

  // resistance, top bit search, normalize
  logic [DIV_BITS-1:0] res_a;
  logic [DIV_BITS-1:0] res_b;
  logic [4:0]          exp_b;
  logic [4:0]          exp_next;
  logic [30:0]         man_c;
  logic [4:0]          exp_c;
  logic [30:0]         man_ext;

  always_comb begin
    exp_next = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      if (res_a[i]) exp_next = 5'(i);
    end
  end

  assign man_ext = 31'(res_b);

  always_ff @(posedge clk) begin
    if (en) begin
      res_a <= (dv_quo[DIV_BITS] <= SERIES_OHMS) ? DIV_BITS'(1)
                                                 : dv_quo[DIV_BITS] - SERIES_OHMS;
      res_b <= res_a;
      exp_b <= exp_next;
      man_c <= man_ext << (5'd30 - exp_b);
      exp_c <= exp_b;
    end
  end

  // fraction bits of log2 by repeated squaring
  logic [30:0]         sq_m [1:SQ_STEPS];
  logic [4:0]          sq_e [1:SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_f [1:SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    logic [30:0]         prev_m;
    logic [4:0]          prev_e;
    logic [SQ_STEPS-1:0] prev_f;
    logic [61:0]         prod;
    logic [31:0]         sq;
    if (j == 0) begin : g_first
      assign prev_m = man_c;
      assign prev_e = exp_c;
      assign prev_f = '0;
    end else begin : g_next
      assign prev_m = sq_m[j];
      assign prev_e = sq_e[j];
      assign prev_f = sq_f[j];
    end
    assign prod = 62'(prev_m) * 62'(prev_m);
    assign sq = prod[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        sq_m[j+1] <= sq[31] ? sq[31:1] : sq[30:0];
        sq_e[j+1] <= prev_e;
        sq_f[j+1] <= {prev_f[SQ_STEPS-2:0], sq[31]};
      end
    end
  end

  // natural log and polynomial
  logic [32:0] lg;
  logic [62:0] lprod;
  logic [28:0] ln_v;
  logic [57:0] p2;
  logic [33:0] ln2_v;
  logic [28:0] ln_v2;
  logic [62:0] p3;
  logic [56:0] pb;
  logic [38:0] ln3_v;
  logic [40:0] bterm;
  logic [63:0] pc;
  logic [39:0] cterm;
  logic [40:0] bterm_d;
  logic [41:0] dval;

  assign lg = {sq_e[SQ_STEPS], sq_f[SQ_STEPS]};
  assign lprod = 63'(lg) * 63'(LN2_Q30);
  assign p2 = 58'(ln_v) * 58'(ln_v);
  assign p3 = 63'(ln2_v) * 63'(ln_v2);
  assign pb = 57'(ln_v2) * 57'(COEF_B_Q40);
  assign pc = 64'(ln3_v) * 64'(COEF_C_Q48);

  always_ff @(posedge clk) begin
    if (en) begin
      ln_v    <= lprod[62:34];
      ln2_v   <= p2[57:24];
      ln_v2   <= ln_v;
      ln3_v   <= p3[62:24];
      bterm   <= pb[56:16];
      cterm   <= pc[63:24];
      bterm_d <= bterm;
      dval    <= COEF_A_Q48 + 42'(bterm_d) + 42'(cterm);
    end
  end

  // rounded reciprocal, one quotient bit per stage
  logic [56:0]         qt_rem [1:QUO_BITS];
  logic [41:0]         qt_den [1:QUO_BITS];
  logic [QUO_BITS-1:0] qt_quo [1:QUO_BITS];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_rcp
    logic [56:0]         prev_rem;
    logic [41:0]         prev_den;
    logic [QUO_BITS-1:0] prev_quo;
    logic [59:0]         dsh;
    logic [59:0]         rem_w;
    logic                ge;
    if (j == 0) begin : g_first
      assign prev_rem = 57'(SCALE_Q48) + 57'(dval >> 1);
      assign prev_den = dval;
      assign prev_quo = '0;
    end else begin : g_next
      assign prev_rem = qt_rem[j];
      assign prev_den = qt_den[j];
      assign prev_quo = qt_quo[j];
    end
    assign dsh = 60'(prev_den) << (QUO_BITS - 1 - j);
    assign rem_w = 60'(prev_rem);
    assign ge = rem_w >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        qt_rem[j+1] <= ge ? 57'(rem_w - dsh) : prev_rem;
        qt_den[j+1] <= prev_den;
        qt_quo[j+1] <= {prev_quo[QUO_BITS-2:0], ge};
      end
    end
  end

  assign quo = qt_quo[QUO_BITS];
endmodule
`default_nettype wire

// ===== rtl/core/dtf_merge.sv =====
// offset, fault masking and mean of both lanes, output register
`timescale 1ns / 1ps
`default_nettype none
module dtf_merge import dtf_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [QUO_BITS-1:0] quo_a,
  input  logic [QUO_BITS-1:0] quo_b,
  input  logic [1:0]          flt,
  input  logic [11:0]         offset,
  output logic [17:0]         temp_a,
  output logic [17:0]         temp_b,
  output logic [17:0]         temp_mean,
  output logic [1:0]          fault
);
  logic signed [19:0] off_w;
  logic signed [19:0] ta;
  logic signed [19:0] tb;
  logic signed [19:0] sum;
  logic signed [19:0] mean;

  assign off_w = 20'(signed'(offset));
  assign ta = signed'(20'(quo_a)) - KELVIN_FAHR_CENTI + off_w;
  assign tb = signed'(20'(quo_b)) - KELVIN_FAHR_CENTI + off_w;
  assign sum = ta + tb;
  assign mean = sum >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      temp_a    <= flt[0] ? '0 : ta[17:0];
      temp_b    <= flt[1] ? '0 : tb[17:0];
      temp_mean <= (flt != 2'b00) ? '0 : mean[17:0];
      fault     <= flt;
    end
  end
endmodule
`default_nettype wire

// ===== sim/dual_thermistor_to_fahrenheit_test.sv =====
// self-checking testbench for the dual thermistor to fahrenheit converter
`timescale 1ns / 1ps
module dual_thermistor_to_fahrenheit_test;
  import dtf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [17:0] temp_a;
    logic [17:0] temp_b;
    logic [17:0] temp_mean;
    logic [1:0]  fault;
  } reading_t;

  class fahrenheit_scoreboard;
    reading_t pending[$];
    longint offset_centi;
    int errors;

    function new();
      offset_centi = 0;
      errors = 0;
    endfunction

    function void set_offset(logic [31:0] value);
      offset_centi = longint'(signed'(value[11:0]));
    endfunction

    function longint unsigned ln_q24(longint unsigned r);
      int e;
      longint unsigned m, frac;
      e = 0;
      frac = 0;
      while (e < 23 && (r >> (e + 1)) != 0) e++;
      m = r << (30 - e);
      for (int i = 0; i < SQ_STEPS; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return (((64'(e)) << 28 | frac) * 64'(LN2_Q30)) >> 34;
    endfunction

    function longint lane_centi(logic [9:0] s);
      longint r;
      longint unsigned l, l2, l3, d, q;
      r = longint'(64'(DIVIDEND) / 64'(s)) - longint'(64'(SERIES_OHMS));
      if (r < 1) r = 1;
      l = ln_q24(r);
      l2 = (l * l) >> 24;
      l3 = (l2 * l) >> 24;
      d = 64'(COEF_A_Q48) + ((64'(COEF_B_Q40) * l) >> 16) + ((64'(COEF_C_Q48) * l3) >> 24);
      q = (64'(SCALE_Q48) + (d >> 1)) / d;
      return longint'(q) - 45967 + offset_centi;
    endfunction

    function void note(logic [9:0] a, logic [9:0] b);
      reading_t exp_r;
      longint ta, tb, mean;
      ta = (a == 0) ? 0 : lane_centi(a);
      tb = (b == 0) ? 0 : lane_centi(b);
      exp_r.fault = {b == 0, a == 0};
      mean = (exp_r.fault == 0) ? ((ta + tb) >>> 1) : 0;
      exp_r.temp_a = ta[17:0];
      exp_r.temp_b = tb[17:0];
      exp_r.temp_mean = mean[17:0];
      pending.push_back(exp_r);
    endfunction

    function void check(reading_t got);
      reading_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.temp_a !== exp_r.temp_a) begin
        $error("temp_a expected %0d got %0d", $signed(exp_r.temp_a), $signed(got.temp_a));
        errors++;
      end
      if (got.temp_b !== exp_r.temp_b) begin
        $error("temp_b expected %0d got %0d", $signed(exp_r.temp_b), $signed(got.temp_b));
        errors++;
      end
      if (got.temp_mean !== exp_r.temp_mean) begin
        $error("temp_mean expected %0d got %0d",
               $signed(exp_r.temp_mean), $signed(got.temp_mean));
        errors++;
      end
      if (got.fault !== exp_r.fault) begin
        $error("fault expected %0d got %0d", exp_r.fault, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] sample_a = '0, sample_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [17:0] temp_a, temp_b, temp_mean;
  logic [1:0] fault;

  fahrenheit_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  dual_thermistor_to_fahrenheit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_a(sample_a), .sample_b(sample_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .temp_a(temp_a), .temp_b(temp_b), .temp_mean(temp_mean), .fault(fault)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check({temp_a, temp_b, temp_mean, fault});
  end

  // receiver: long hold-off first, else random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_offset(logic [11:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = '0;
    pwdata = {20'($urandom_range(20'hFFFFF)), value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.set_offset(pwdata);
  endtask

  task automatic send_pair(logic [9:0] a, logic [9:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_a = a;
    sample_b = b;
    do @(posedge clk); while (!in_ready);
    sb.note(a, b);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [9:0] rand_sample();
    if ($urandom_range(99) < 5) return '0;
    return 10'($urandom_range(1023));
  endfunction

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(logic [11:0] offset, int send_pct, int recv_pct, int n);
    drain();
    write_offset(offset);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) send_pair(rand_sample(), rand_sample());
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // extremes, faults, mean rounding of negatives at reset offset
    send_pair(10'd0, 10'd0);
    send_pair(10'd0, 10'd512);
    send_pair(10'd512, 10'd0);
    send_pair(10'd1, 10'd1023);
    send_pair(10'd1023, 10'd1);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd1, 10'd1);
    send_pair(10'd2, 10'd1022);
    send_pair(10'h155, 10'h2AA);
    send_pair(10'h2AA, 10'h155);
    send_pair(10'd511, 10'd513);
    send_pair(10'd3, 10'd4);
    send_pair(10'd1000, 10'd999);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd1, 10'd0);

    // long output hold-off while input keeps streaming
    drain();
    write_offset(12'sd2000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    repeat (300) send_pair(rand_sample(), rand_sample());

    run_phase(-12'sd2000, 46, 0, 250);
    run_phase(-12'sd2048, 0, 46, 250);
    run_phase(12'sd2047, 8, 8, 250);
    run_phase(12'($urandom_range(4095)), 0, 0, 200);
    run_phase(12'd0, 46, 46, 250);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
